/* hw/rtl/p2a_pkg.sv */
// ----------------------------------------------------------------------------
// p2a_pkg
// Shared types, palette tables and glyph ramp for the pixel-to-cell unit.
// ----------------------------------------------------------------------------
package p2a_pkg;

  localparam int NUM_PAL = 16;
  localparam int NUM_CH  = 3;
  localparam int NUM_LVL = 4;
  localparam int DIST_W  = 18;

  // Per-stage load enables of the distance front end
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

  // Candidate in the nearest-colour search
  typedef struct packed {
    logic [DIST_W-1:0] dsq;
    logic [3:0]        idx;
  } cand_t;

  // The palette uses only four distinct channel values
  localparam logic [7:0] LVL_VAL [NUM_LVL] = '{8'h00, 8'h80, 8'hc0, 8'hff};

  // Channel value selector for each palette entry: red, green, blue
  localparam logic [1:0] PAL_SEL [NUM_PAL][NUM_CH] = '{
    '{2'd0, 2'd0, 2'd0}, '{2'd1, 2'd0, 2'd0}, '{2'd0, 2'd1, 2'd0}, '{2'd1, 2'd1, 2'd0},
    '{2'd0, 2'd0, 2'd1}, '{2'd1, 2'd0, 2'd1}, '{2'd0, 2'd1, 2'd1}, '{2'd2, 2'd2, 2'd2},
    '{2'd1, 2'd1, 2'd1}, '{2'd3, 2'd0, 2'd0}, '{2'd0, 2'd3, 2'd0}, '{2'd3, 2'd3, 2'd0},
    '{2'd0, 2'd0, 2'd3}, '{2'd3, 2'd0, 2'd3}, '{2'd0, 2'd3, 2'd3}, '{2'd3, 2'd3, 2'd3}
  };

  // Keep the lower-index candidate a unless b is strictly nearer
  function automatic cand_t pick_near(input cand_t a, input cand_t b);
    return (b.dsq < a.dsq) ? b : a;
  endfunction

  // Brightness glyph ramp, darkest first
  function automatic logic [6:0] glyph_of(input logic [4:0] level);
    logic [6:0] g;
    case (level)
      5'd0:    g = 7'h20;  // space
      5'd1:    g = 7'h2e;  // .
      5'd2:    g = 7'h2c;  // ,
      5'd3:    g = 7'h3a;  // :
      5'd4:    g = 7'h7e;  // ~
      5'd5:    g = 7'h3d;  // =
      5'd6:    g = 7'h2b;  // +
      5'd7:    g = 7'h3f;  // ?
      5'd8:    g = 7'h49;  // I
      5'd9:    g = 7'h37;  // 7
      5'd10:   g = 7'h5a;  // Z
      5'd11:   g = 7'h4f;  // O
      5'd12:   g = 7'h38;  // 8
      5'd13:   g = 7'h4e;  // N
      5'd14:   g = 7'h4d;  // M
      5'd15:   g = 7'h23;  // #
      default: g = 7'h40;  // @ for the top level
    endcase
    return g;
  endfunction

endpackage

/* hw/rtl/pixel_to_ansi_cell_unit.sv */
// ----------------------------------------------------------------------------
// pixel_to_ansi_cell_unit
// Maps an RRGGBBAA pixel to a terminal cell: nearest 16-colour ANSI palette
// entry (bright bit and colour digit) and a brightness glyph.
// ----------------------------------------------------------------------------
// The unit takes one pixel per clock while the output is not stalled, and
// returns one cell per pixel, in order. The five register stages
// are: channel differences, squares, palette distances, a 16-to-4 minimum
// search, and a 4-to-1 minimum search that loads the output register. Each
// stage moves on whenever the stage after it is empty or moving, so bubbles
// are squeezed out and a stalled output holds the pipeline without loss.
// Alpha is ignored; on equal distances the lowest palette index wins.
module pixel_to_ansi_cell_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] pixel_word
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [0] bright_flag, [3:1] base_colour,
                                  // [8:4] level_index, [15:9] glyph_code
);

  localparam int GRP = p2a_pkg::NUM_PAL / 4;

  p2a_pkg::stage_en_t          fe_en;
  logic                        v1_r, v2_r, v3_r, v4_r;
  logic                        v1_nxt, v2_nxt, v3_nxt, v4_nxt, out_valid_nxt;
  logic                        en1, en2, en3, en4, en5;
  logic [p2a_pkg::DIST_W-1:0]  pal_dist [p2a_pkg::NUM_PAL];
  logic [4:0]                  level3;

  p2a_pkg::cand_t              grp_best [GRP];
  p2a_pkg::cand_t              grp_r    [GRP];
  logic [4:0]                  level4_r;
  logic [6:0]                  glyph4_r;
  p2a_pkg::cand_t              fin_best;

  // Back-propagate stage enables from the output
  always_comb begin
    en5 = !out_tvalid || out_tready;
    en4 = !v4_r || en5;
    en3 = !v3_r || en4;
    en2 = !v2_r || en3;
    en1 = !v1_r || en2;
  end

  assign in_tready = en1;
  assign fe_en     = '{s1: en1, s2: en2, s3: en3};

  // Advance valid bits alongside the data
  always_comb begin
    v1_nxt        = en1 ? in_tvalid : v1_r;
    v2_nxt        = en2 ? v1_r      : v2_r;
    v3_nxt        = en3 ? v2_r      : v3_r;
    v4_nxt        = en4 ? v3_r      : v4_r;
    out_valid_nxt = en5 ? v4_r      : out_tvalid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      v3_r       <= 1'b0;
      v4_r       <= 1'b0;
      out_tvalid <= 1'b0;
    end else begin
      v1_r       <= v1_nxt;
      v2_r       <= v2_nxt;
      v3_r       <= v3_nxt;
      v4_r       <= v4_nxt;
      out_tvalid <= out_valid_nxt;
    end
  end

  // Stages 1 to 3: distances and brightness level
  p2a_front u_front (
    .clk      (clk),
    .en       (fe_en),
    .pix_word (in_tdata),
    .dist_r   (pal_dist),
    .level_r  (level3)
  );

  // Stage 4: nearest entry within each group of four
  always_comb begin
    for (int g = 0; g < GRP; g++) begin
      grp_best[g] = p2a_pkg::pick_near(
        p2a_pkg::pick_near(p2a_pkg::cand_t'{dsq: pal_dist[4*g],   idx: 4'(4*g)},
                           p2a_pkg::cand_t'{dsq: pal_dist[4*g+1], idx: 4'(4*g+1)}),
        p2a_pkg::pick_near(p2a_pkg::cand_t'{dsq: pal_dist[4*g+2], idx: 4'(4*g+2)},
                           p2a_pkg::cand_t'{dsq: pal_dist[4*g+3], idx: 4'(4*g+3)}));
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      for (int g = 0; g < GRP; g++) begin
        grp_r[g] <= grp_best[g];
      end
      level4_r <= level3;
      glyph4_r <= p2a_pkg::glyph_of(level3);
    end
  end

  // Stage 5: nearest entry overall, load the output register
  assign fin_best = p2a_pkg::pick_near(p2a_pkg::pick_near(grp_r[0], grp_r[1]),
                                       p2a_pkg::pick_near(grp_r[2], grp_r[3]));

  always_ff @(posedge clk) begin
    if (en5) begin
      out_tdata <= {glyph4_r, level4_r, fin_best.idx[2:0], fin_best.idx[3]};
    end
  end

  // A stall at the input only comes from a held result at the output
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without a held result");

  // Glyph and level of a result come from the same item
  a_glyph_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[15:9] == p2a_pkg::glyph_of(out_tdata[8:4])))
    else $error("glyph does not match level");

  // Level never exceeds the top of the ramp
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[8:4] <= 5'd16))
    else $error("level out of range");

  // Nothing leaves the pipeline right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result valid after reset");

endmodule

/* hw/rtl/p2a_front.sv */
// ----------------------------------------------------------------------------
// p2a_front
// Three-stage front end: channel differences, squares, then the sixteen
// palette distances alongside the brightness level.
// ----------------------------------------------------------------------------
module p2a_front (
  input  logic                        clk,
  input  p2a_pkg::stage_en_t          en,
  input  logic [31:0]                 pix_word,
  output logic [p2a_pkg::DIST_W-1:0]  dist_r [p2a_pkg::NUM_PAL],
  output logic [4:0]                  level_r
);

  logic [7:0]  diff_r [p2a_pkg::NUM_CH][p2a_pkg::NUM_LVL];
  logic [9:0]  sum_r;
  logic [15:0] sq_r   [p2a_pkg::NUM_CH][p2a_pkg::NUM_LVL];
  logic [7:0]  avg_r;

  logic [7:0]  chan      [p2a_pkg::NUM_CH];
  logic [19:0] avg_prod;
  logic [11:0] lvl_x;
  logic [12:0] lvl_t;

  // Split the pixel into red, green and blue
  always_comb begin
    chan[0] = pix_word[31:24];
    chan[1] = pix_word[23:16];
    chan[2] = pix_word[15:8];
  end

  // Stage 1: absolute difference to each palette channel value, channel sum
  always_ff @(posedge clk) begin
    if (en.s1) begin
      for (int c = 0; c < p2a_pkg::NUM_CH; c++) begin
        for (int k = 0; k < p2a_pkg::NUM_LVL; k++) begin
          diff_r[c][k] <= (chan[c] > p2a_pkg::LVL_VAL[k]) ?
                          (chan[c] - p2a_pkg::LVL_VAL[k]) :
                          (p2a_pkg::LVL_VAL[k] - chan[c]);
        end
      end
      sum_r <= {2'b00, chan[0]} + {2'b00, chan[1]} + {2'b00, chan[2]};
    end
  end

  // Divide the sum by three: multiply by 683 / 2048, exact for sums up to 765
  assign avg_prod = {10'd0, sum_r} * 20'd683;

  // Stage 2: square the differences, form the average
  always_ff @(posedge clk) begin
    if (en.s2) begin
      for (int c = 0; c < p2a_pkg::NUM_CH; c++) begin
        for (int k = 0; k < p2a_pkg::NUM_LVL; k++) begin
          sq_r[c][k] <= {8'd0, diff_r[c][k]} * {8'd0, diff_r[c][k]};
        end
      end
      avg_r <= avg_prod[18:11];
    end
  end

  // floor(16 * avg / 255) as (x + (x >> 8) + 1) >> 8 with x = 16 * avg
  assign lvl_x = {avg_r, 4'd0};
  assign lvl_t = {1'b0, lvl_x} + {9'd0, lvl_x[11:8]} + 13'd1;

  // Stage 3: sum squared differences per palette entry, register level
  always_ff @(posedge clk) begin
    if (en.s3) begin
      for (int i = 0; i < p2a_pkg::NUM_PAL; i++) begin
        dist_r[i] <= {2'b00, sq_r[0][p2a_pkg::PAL_SEL[i][0]]}
                   + {2'b00, sq_r[1][p2a_pkg::PAL_SEL[i][1]]}
                   + {2'b00, sq_r[2][p2a_pkg::PAL_SEL[i][2]]};
      end
      level_r <= lvl_t[12:8];
    end
  end

endmodule

/* bench/pixel_to_ansi_cell_checker.sv */
// ----------------------------------------------------------------------------
// pixel_to_ansi_cell_checker
// Watches both streams of the pixel-to-cell unit. Predicts the cell for each
// accepted pixel and checks every returned cell against the oldest prediction.
// ----------------------------------------------------------------------------
module pixel_to_ansi_cell_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] pixel_word
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // [0] bright_flag, [3:1] base_colour,
                                  // [8:4] level_index, [15:9] glyph_code
  output int          fail_count,
  output int          cells_waiting,
  output int          cells_checked
);

  // Cell layout, packed so that bright_flag sits in bit 0
  typedef struct packed {
    logic [6:0] glyph;
    logic [4:0] level;
    logic [2:0] colour;
    logic       bright;
  } ansi_cell_t;

  localparam int MAX_PRINTED = 40;

  // 16-colour terminal palette as 0xRRGGBB
  localparam logic [23:0] ANSI_RGB [16] = '{
    24'h000000, 24'h800000, 24'h008000, 24'h808000,
    24'h000080, 24'h800080, 24'h008080, 24'hc0c0c0,
    24'h808080, 24'hff0000, 24'h00ff00, 24'hffff00,
    24'h0000ff, 24'hff00ff, 24'h00ffff, 24'hffffff
  };

  // Brightness ramp, darkest first: " .,:~=+?I7ZO8NM#@"
  localparam logic [7:0] SHADE_RAMP [17] = '{
    8'h20, 8'h2e, 8'h2c, 8'h3a, 8'h7e, 8'h3d, 8'h2b, 8'h3f, 8'h49,
    8'h37, 8'h5a, 8'h4f, 8'h38, 8'h4e, 8'h4d, 8'h23, 8'h40
  };

  ansi_cell_t expected_cells [$];
  int         mismatch_total;
  int         waiting_total;
  int         checked_total;

  assign fail_count    = mismatch_total;
  assign cells_waiting = waiting_total;
  assign cells_checked = checked_total;

  // Nearest palette entry by squared RGB distance, lowest index on a tie,
  // plus the average-brightness glyph; alpha never enters
  function automatic ansi_cell_t quantize_pixel(input logic [31:0] px);
    ansi_cell_t pred;
    int         red;
    int         grn;
    int         blu;
    int         dr;
    int         dg;
    int         db;
    int         sq_sum;
    int         best_dist;
    int         best_idx;
    int         avg;
    int         lvl;
    red       = int'(px[31:24]);
    grn       = int'(px[23:16]);
    blu       = int'(px[15:8]);
    best_dist = 32'h7fffffff;
    best_idx  = 0;
    for (int i = 0; i < 16; i++) begin
      dr     = red - int'(ANSI_RGB[i][23:16]);
      dg     = grn - int'(ANSI_RGB[i][15:8]);
      db     = blu - int'(ANSI_RGB[i][7:0]);
      sq_sum = dr * dr + dg * dg + db * db;
      if (sq_sum < best_dist) begin
        best_dist = sq_sum;
        best_idx  = i;
      end
    end
    avg         = (red + grn + blu) / 3;
    lvl         = (avg * 16) / 255;
    pred.bright = best_idx[3];
    pred.colour = best_idx[2:0];
    pred.level  = lvl[4:0];
    pred.glyph  = SHADE_RAMP[lvl][6:0];
    return pred;
  endfunction

  // Print one line per mismatch (up to a cap) and count every one
  task automatic report_mismatch(input string what, input int exp_val, input int got_val);
    mismatch_total++;
    if (mismatch_total <= MAX_PRINTED)
      $display("mismatch at cell %0d: %s expected %0d got %0d",
               checked_total, what, exp_val, got_val);
  endtask

  initial begin
    mismatch_total = 0;
    waiting_total  = 0;
    checked_total  = 0;
  end

  // Predict on each accepted pixel, compare on each accepted cell
  always @(posedge clk) begin
    ansi_cell_t want;
    ansi_cell_t got;
    if (!rst_n) begin
      expected_cells.delete();
    end else begin
      if (in_tvalid && in_tready)
        expected_cells.push_back(quantize_pixel(in_tdata));
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_cells.size() == 0) begin
          report_mismatch("unexpected cell, raw data", 0, int'(out_tdata));
        end else begin
          want = expected_cells.pop_front();
          if (got.bright !== want.bright)
            report_mismatch("bright_flag", int'(want.bright), int'(got.bright));
          if (got.colour !== want.colour)
            report_mismatch("base_colour", int'(want.colour), int'(got.colour));
          if (got.level !== want.level)
            report_mismatch("level_index", int'(want.level), int'(got.level));
          if (got.glyph !== want.glyph)
            report_mismatch("glyph_code", int'(want.glyph), int'(got.glyph));
        end
        checked_total++;
      end
    end
    waiting_total = expected_cells.size();
  end

endmodule

/* bench/pixel_to_ansi_cell_unit_test.sv */
// ----------------------------------------------------------------------------
// pixel_to_ansi_cell_unit_test
// Drives pixel words into the unit with random gaps and output stalls: a
// directed set of palette hits, ties and level edges, then a random mix.
// ----------------------------------------------------------------------------
module pixel_to_ansi_cell_unit_test;

  localparam int RANDOM_PIXELS = 1100;
  localparam int LONG_HOLD     = 300;
  localparam int DRAIN_CYCLES  = 12;

  // Palette colours, used to aim random pixels near entries and midpoints
  localparam logic [23:0] PALETTE [16] = '{
    24'h000000, 24'h800000, 24'h008000, 24'h808000,
    24'h000080, 24'h800080, 24'h008080, 24'hc0c0c0,
    24'h808080, 24'hff0000, 24'h00ff00, 24'hffff00,
    24'h0000ff, 24'hff00ff, 24'h00ffff, 24'hffffff
  };

  // Directed pixels: extremes, every palette entry with varied alpha,
  // equal-distance ties, level boundaries and an alpha-only pair
  localparam logic [31:0] DIRECTED [25] = '{
    32'h00000000, 32'hffffffff, 32'hffffff00, 32'h80000033, 32'h008000cc,
    32'h80800001, 32'h000080fe, 32'h80008055, 32'h008080aa, 32'hc0c0c07f,
    32'h80808080, 32'hff000000, 32'h00ff0011, 32'hffff0022, 32'h0000ff44,
    32'hff00ff66, 32'h00ffff88, 32'h40000000, 32'ha0a0a0ff, 32'h40404000,
    32'h0f0f0f00, 32'h10101000, 32'h01000000, 32'h12345600, 32'h123456ff
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;

  int fail_count;
  int cells_waiting;
  int cells_checked;
  int pixels_sent;
  int long_holds;
  bit quiet;
  bit hold_request;

  pixel_to_ansi_cell_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  pixel_to_ansi_cell_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .fail_count    (fail_count),
    .cells_waiting (cells_waiting),
    .cells_checked (cells_checked)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Mostly no gap, often a short one, now and then a long one
  function automatic int gap_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] nudge(input logic [7:0] chan);
    int v;
    v = int'(chan) + $urandom_range(0, 16) - 8;
    if (v < 0)   v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  // Random pixel: uniform words, near-palette colours, grays and midpoints
  function automatic logic [31:0] random_pixel();
    int          pick;
    logic [23:0] pa;
    logic [23:0] pb;
    logic [7:0]  gray;
    logic [7:0]  alpha;
    pick  = $urandom_range(0, 99);
    pa    = PALETTE[$urandom_range(0, 15)];
    pb    = PALETTE[$urandom_range(0, 15)];
    gray  = 8'($urandom_range(0, 255));
    alpha = 8'($urandom_range(0, 255));
    if (pick < 50) return $urandom;
    if (pick < 75) return {nudge(pa[23:16]), nudge(pa[15:8]), nudge(pa[7:0]), alpha};
    if (pick < 90) return {gray, gray, gray, alpha};
    return {8'((pa[23:16] + pb[23:16]) >> 1), 8'((pa[15:8] + pb[15:8]) >> 1),
            8'((pa[7:0] + pb[7:0]) >> 1), alpha};
  endfunction

  // Offer one pixel after an optional gap and hold it until accepted
  task automatic push_pixel(input logic [31:0] word);
    int gap;
    gap = quiet ? 0 : gap_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pixels_sent++;
  endtask

  // Receiver: random stalls, plus one long hold when asked for
  initial begin
    int stall_left;
    stall_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = LONG_HOLD;
        long_holds++;
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (quiet || $urandom_range(0, 99) < 70) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        stall_left = gap_len();
      end
    end
  end

  // Stimulus and verdict
  initial begin
    pixels_sent  = 0;
    long_holds   = 0;
    quiet        = 1'b0;
    hold_request = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i]) push_pixel(DIRECTED[i]);

    // Pause the source until every cell has come back
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (cells_waiting != 0) @(posedge clk);

    for (int n = 0; n < RANDOM_PIXELS; n++) begin
      if (n % 150 == 0) quiet = ($urandom_range(0, 2) == 0);
      if (n == 300) hold_request = 1'b1;
      if (n == 700) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (cells_waiting != 0) @(posedge clk);
      end
      push_pixel(random_pixel());
    end

    // Drain the pipeline
    in_tvalid <= 1'b0;
    quiet = 1'b1;
    @(posedge clk);
    while (cells_waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d pixels (%0d directed), %0d cells checked, %0d long output hold(s)",
             pixels_sent, $size(DIRECTED), cells_checked, long_holds);
    $display("stimulus mixed palette hits, ties, gray levels and uniform words");
    if (fail_count == 0 && cells_waiting == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(20 * 600000);
    $display("timeout with %0d cells outstanding", cells_waiting);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
